[design/iwsg_pkg.sv]
// Shared types and constants for the I2C waveform sample generator.
package iwsg_pkg;

	// Samples per bit slot, and bit slots in a byte transfer (8 data + ACK).
	localparam int unsigned SLOT_SAMPLES = 3;
	localparam int unsigned SLOT_COUNT = 9;
	localparam int unsigned PHASE_W = $clog2(SLOT_SAMPLES);
	localparam int unsigned SLOT_W = $clog2(SLOT_COUNT);

	// Default depth of the job queue between the front and back ends.
	localparam int unsigned JOB_FIFO_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_ADDR  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_BYTE,
		ST_STOP
	} state_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       ack_after_read;
		logic       read_not_write;
	} item_t;

	typedef struct packed {
		logic scl_level;
		logic sda_level;
		logic last_sample;
	} result_t;

	// One classified operation: where the sequence begins, whether a byte
	// follows a start, and the SDA level of each slot, first slot in the MSB.
	typedef struct packed {
		state_t                first_state;
		logic                  has_byte;
		logic [SLOT_COUNT-1:0] slot_bits;
	} job_t;

endpackage

[design/iwsg_job_fifo.sv]
// Small flop-based queue of classified jobs.
module iwsg_job_fifo #(
	parameter int unsigned DEPTH = iwsg_pkg::JOB_FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  iwsg_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output iwsg_pkg::job_t pop_job,
	output logic           nempty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	iwsg_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full = (count_q == CW'(DEPTH));
	assign nempty = (count_q != '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/iwsg_front.sv]
// Front end: accept operations and classify them into jobs.
module iwsg_front (
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  iwsg_pkg::item_t cmd_data,
	input  logic            full,
	output logic            push,
	output iwsg_pkg::job_t  push_job
);

	logic known;

	assign cmd_stall = full;

	always_comb begin
		known = 1'b1;
		push_job.first_state = iwsg_pkg::ST_IDLE;
		push_job.has_byte = 1'b0;
		push_job.slot_bits = '1;
		case (cmd_data.opcode)
			iwsg_pkg::OP_START: begin
				push_job.first_state = iwsg_pkg::ST_START;
			end
			iwsg_pkg::OP_STOP: begin
				push_job.first_state = iwsg_pkg::ST_STOP;
			end
			iwsg_pkg::OP_WRITE: begin
				// data MSB first, then released ACK slot
				push_job.first_state = iwsg_pkg::ST_BYTE;
				push_job.slot_bits = {cmd_data.data_byte, 1'b1};
			end
			iwsg_pkg::OP_READ: begin
				// released for eight slots, ACK driven low when ack_after_read is set
				push_job.first_state = iwsg_pkg::ST_BYTE;
				push_job.slot_bits = {8'hFF, ~cmd_data.ack_after_read};
			end
			iwsg_pkg::OP_ADDR: begin
				push_job.first_state = iwsg_pkg::ST_START;
				push_job.has_byte = 1'b1;
				push_job.slot_bits = {cmd_data.data_byte[6:0], cmd_data.read_not_write, 1'b1};
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	// Drop unknown opcodes: they are accepted but produce no samples.
	assign push = cmd_valid && !full && known;

endmodule

[design/iwsg_back.sv]
// Back end: sequence each job into line samples behind an output register.
module iwsg_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_nempty,
	input  iwsg_pkg::job_t    job,
	output logic              pop,
	output logic              sample_valid,
	input  logic              sample_stall,
	output iwsg_pkg::result_t sample_data
);

	localparam logic [iwsg_pkg::PHASE_W-1:0] PH_LAST = iwsg_pkg::PHASE_W'(iwsg_pkg::SLOT_SAMPLES - 1);
	localparam logic [iwsg_pkg::SLOT_W-1:0] SLOT_LAST = iwsg_pkg::SLOT_W'(iwsg_pkg::SLOT_COUNT - 1);

	iwsg_pkg::state_t state_q, state_d;
	logic [iwsg_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [iwsg_pkg::SLOT_W-1:0] slot_q, slot_d;
	iwsg_pkg::job_t job_q;
	iwsg_pkg::result_t cur;
	iwsg_pkg::result_t out_q;
	logic out_valid_q;
	logic busy;
	logic emit;
	logic free;
	logic [iwsg_pkg::SLOT_W-1:0] bit_idx;

	assign busy = (state_q != iwsg_pkg::ST_IDLE);
	assign emit = busy && (!out_valid_q || !sample_stall);
	assign bit_idx = SLOT_LAST - slot_q;

	// Next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		slot_d = slot_q;
		free = !busy;
		pop = 1'b0;
		if (emit) begin
			if (phase_q == PH_LAST) begin
				phase_d = '0;
				case (state_q)
					iwsg_pkg::ST_START: begin
						if (job_q.has_byte) begin
							state_d = iwsg_pkg::ST_BYTE;
							slot_d = '0;
						end else begin
							free = 1'b1;
						end
					end
					iwsg_pkg::ST_BYTE: begin
						if (slot_q == SLOT_LAST) begin
							free = 1'b1;
						end else begin
							slot_d = slot_q + 1'b1;
						end
					end
					default: begin
						free = 1'b1;
					end
				endcase
			end else begin
				phase_d = phase_q + 1'b1;
			end
		end
		if (free) begin
			state_d = iwsg_pkg::ST_IDLE;
			if (job_nempty) begin
				pop = 1'b1;
				state_d = job.first_state;
				phase_d = '0;
				slot_d = '0;
			end
		end
	end

	// Sample for the current position
	always_comb begin
		cur = '0;
		case (state_q)
			iwsg_pkg::ST_START: begin
				cur.scl_level = (phase_q != PH_LAST);
				cur.sda_level = (phase_q == '0);
				cur.last_sample = (phase_q == PH_LAST) && !job_q.has_byte;
			end
			iwsg_pkg::ST_BYTE: begin
				cur.scl_level = (phase_q == iwsg_pkg::PHASE_W'(1));
				cur.sda_level = job_q.slot_bits[bit_idx];
				cur.last_sample = (phase_q == PH_LAST) && (slot_q == SLOT_LAST);
			end
			iwsg_pkg::ST_STOP: begin
				cur.scl_level = (phase_q != '0);
				cur.sda_level = (phase_q == PH_LAST);
				cur.last_sample = (phase_q == PH_LAST);
			end
			default: begin
				cur = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= job;
		end
		if (emit) begin
			out_q <= cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iwsg_pkg::ST_IDLE;
			phase_q <= '0;
			slot_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			slot_q <= slot_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!sample_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sample_valid = out_valid_q;
	assign sample_data = out_q;

endmodule

[design/i2c_waveform_sample_generator_unit.sv]
// Top level of the I2C master waveform sample generator.
//
//   channel   direction  handshake                   payload
//   cmd       in         cmd_valid / cmd_stall       cmd_data    (iwsg_pkg::item_t)
//   sample    out        sample_valid / sample_stall sample_data (iwsg_pkg::result_t)
//
// One line sample leaves per cycle while the output is not stalled. Start and stop
// give 3 samples each, a write or read byte 27, start plus address 30, unknown none.
// Into an idle block, a transfer is queued, then sequenced, then sample_valid rises.
// Queued jobs run without gaps; cmd_stall rises only when the job queue is full.
// A sample_stall holds a valid output register and freezes the sequencer behind it.
// Reset clears the queue, the sequencer and the output valid at once.
module i2c_waveform_sample_generator_unit #(
	parameter int unsigned JOB_DEPTH = iwsg_pkg::JOB_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  iwsg_pkg::item_t   cmd_data,
	output logic              sample_valid,
	input  logic              sample_stall,
	output iwsg_pkg::result_t sample_data
);

	logic           full;
	logic           push;
	iwsg_pkg::job_t push_job;
	logic           pop;
	iwsg_pkg::job_t pop_job;
	logic           nempty;

	// Classify each transfer into a job; drop unknown opcodes here.
	iwsg_front u_front (
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.full      (full),
		.push      (push),
		.push_job  (push_job)
	);

	// Decouple classification from sequencing.
	iwsg_job_fifo #(
		.DEPTH (JOB_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.pop_job  (pop_job),
		.nempty   (nempty)
	);

	// Walk start, byte slots and stop, three samples per slot.
	iwsg_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_nempty   (nempty),
		.job          (pop_job),
		.pop          (pop),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_data  (sample_data)
	);

endmodule

[design/iwsg_checker.sv]
// Port-level checks for the I2C waveform sample generator, bound to the top.
module iwsg_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              cmd_valid,
	input logic              cmd_stall,
	input iwsg_pkg::item_t   cmd_data,
	input logic              sample_valid,
	input logic              sample_stall,
	input iwsg_pkg::result_t sample_data
);

	// Hold a stalled sample.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_stall |=> sample_valid && $stable(sample_data))
		else $error("stalled sample changed");

	// An operation streams without gaps until its final sample.
	a_stream: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && !sample_data.last_sample |=> sample_valid)
		else $error("gap inside an operation");

	// A final sample with SCL high only ends a stop, with SDA released.
	a_stop_end: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_data.last_sample && sample_data.scl_level
		|-> sample_data.sda_level)
		else $error("final sample with SCL high has SDA low");

endmodule

bind i2c_waveform_sample_generator_unit iwsg_checker u_iwsg_checker (.*);
